@@ hw/rtl/dpb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared constants for the depth pixel back-projection block: frame size,
// field and stream widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Depth frame size in pixels
  localparam int FRAME_WIDTH  = 848;
  localparam int FRAME_HEIGHT = 480;

  // Input field widths
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DEPTH_W = 16;

  // Output field widths
  localparam int POS_W   = 32;
  localparam int CIDX_W  = 24;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_FIELDS_W  = COL_W + ROW_W + DEPTH_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * POS_W + DEPTH_W + CIDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int PRIN_W  = 16;
  localparam int INVF_W  = 24;
  localparam int SCALE_W = 24;
  localparam int RWID_W  = 13;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PRINCIPAL_X     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRINCIPAL_Y     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_LIMIT     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_SCALE_X   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_SCALE_Y   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_ROW_WIDTH = 3'd7;

  // Register reset values
  localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_X     = 16'd6707;
  localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_Y     = 16'd3912;
  localparam logic [INVF_W-1:0]  RST_INV_FOCAL_X     = 24'd39172;
  localparam logic [INVF_W-1:0]  RST_INV_FOCAL_Y     = 24'd39172;
  localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT     = 16'd4000;
  localparam logic [SCALE_W-1:0] RST_COLOR_SCALE_X   = 24'd98923;
  localparam logic [SCALE_W-1:0] RST_COLOR_SCALE_Y   = 24'd98304;
  localparam logic [RWID_W-1:0]  RST_COLOR_ROW_WIDTH = 13'd1280;

endpackage

@@ hw/rtl/depth_pixel_backprojection_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top
// Back-projects one depth pixel per beat to a camera-space point (x, y in
// signed 1/16 mm, z in mm) and the index of the matching colour pixel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   s_axis_tvalid/tready       tdata: column, row, depth_mm
//  m_axis    out  m_axis_tvalid/tready       tdata: x, y, z, color_index;
//                                            tuser: point_valid
//  cfg       in   cfg_we_i (no wait)         cfg_addr_i, cfg_wdata_i
//
//  One beat in and one beat out per clock while m_axis is not stalled,
//  through four register stages (offset/scale multiply, depth multiply,
//  focal multiply, round/saturate into the output register).
//  Reset loads the register defaults and empties the pipeline.
//  A stall on m_axis freezes every stage at once; s_axis_tready drops only
//  while the output register holds a beat that is not taken.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] column, [18:10] row, [34:19] depth_mm, rest zero
  input  logic [dpb_pkg::IN_DATA_W-1:0]     s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] x_pos, [63:32] y_pos, [79:64] z_mm, [103:80] color_index
  output logic [dpb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [0] point_valid
  output logic                              m_axis_tuser,

  input  logic                              cfg_we_i,
  input  logic [dpb_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int DIFF_W = dpb_pkg::PRIN_W + 1;          // 16*coord - principal
  localparam int PD_W   = DIFF_W + dpb_pkg::DEPTH_W;    // diff * depth
  localparam int PROD_W = PD_W + dpb_pkg::INVF_W + 1;   // * inv focal
  localparam int SHR_W  = PROD_W - 24;                  // after >>> 24
  localparam int CXF_W  = dpb_pkg::COL_W + dpb_pkg::SCALE_W;
  localparam int CYF_W  = dpb_pkg::ROW_W + dpb_pkg::SCALE_W;
  localparam int CX_W   = CXF_W - 16;
  localparam int CY_W   = CYF_W - 16;
  localparam int CYW_W  = CY_W + dpb_pkg::RWID_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dpb_pkg::PRIN_W-1:0]  principal_x_q, principal_y_q;
  logic [dpb_pkg::INVF_W-1:0]  inv_focal_x_q, inv_focal_y_q;
  logic [dpb_pkg::DEPTH_W-1:0] depth_limit_q;
  logic [dpb_pkg::SCALE_W-1:0] color_scale_x_q, color_scale_y_q;
  logic [dpb_pkg::RWID_W-1:0]  color_row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      principal_x_q     <= dpb_pkg::RST_PRINCIPAL_X;
      principal_y_q     <= dpb_pkg::RST_PRINCIPAL_Y;
      inv_focal_x_q     <= dpb_pkg::RST_INV_FOCAL_X;
      inv_focal_y_q     <= dpb_pkg::RST_INV_FOCAL_Y;
      depth_limit_q     <= dpb_pkg::RST_DEPTH_LIMIT;
      color_scale_x_q   <= dpb_pkg::RST_COLOR_SCALE_X;
      color_scale_y_q   <= dpb_pkg::RST_COLOR_SCALE_Y;
      color_row_width_q <= dpb_pkg::RST_COLOR_ROW_WIDTH;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        dpb_pkg::REG_PRINCIPAL_X:     principal_x_q     <= cfg_wdata_i[dpb_pkg::PRIN_W-1:0];
        dpb_pkg::REG_PRINCIPAL_Y:     principal_y_q     <= cfg_wdata_i[dpb_pkg::PRIN_W-1:0];
        dpb_pkg::REG_INV_FOCAL_X:     inv_focal_x_q     <= cfg_wdata_i[dpb_pkg::INVF_W-1:0];
        dpb_pkg::REG_INV_FOCAL_Y:     inv_focal_y_q     <= cfg_wdata_i[dpb_pkg::INVF_W-1:0];
        dpb_pkg::REG_DEPTH_LIMIT:     depth_limit_q     <= cfg_wdata_i[dpb_pkg::DEPTH_W-1:0];
        dpb_pkg::REG_COLOR_SCALE_X:   color_scale_x_q   <= cfg_wdata_i[dpb_pkg::SCALE_W-1:0];
        dpb_pkg::REG_COLOR_SCALE_Y:   color_scale_y_q   <= cfg_wdata_i[dpb_pkg::SCALE_W-1:0];
        dpb_pkg::REG_COLOR_ROW_WIDTH: color_row_width_q <= cfg_wdata_i[dpb_pkg::RWID_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the output is stuck
  // --------------------------------------------------------------------------
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  assign adv           = !v4_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic [dpb_pkg::COL_W-1:0]   in_col;
  logic [dpb_pkg::ROW_W-1:0]   in_row;
  logic [dpb_pkg::DEPTH_W-1:0] in_depth;

  assign in_col   = s_axis_tdata[dpb_pkg::COL_W-1:0];
  assign in_row   = s_axis_tdata[dpb_pkg::COL_W+dpb_pkg::ROW_W-1:dpb_pkg::COL_W];
  assign in_depth = s_axis_tdata[dpb_pkg::IN_FIELDS_W-1:dpb_pkg::COL_W+dpb_pkg::ROW_W];

  // --------------------------------------------------------------------------
  // Stage 1: validity, principal offsets, colour scaling products
  // --------------------------------------------------------------------------
  logic                        ok1_d, ok1_q;
  logic signed [DIFF_W-1:0]    dx1_d, dx1_q, dy1_d, dy1_q;
  logic [dpb_pkg::DEPTH_W-1:0] dep1_q;
  logic [CXF_W-1:0]            cxf1_d;
  logic [CYF_W-1:0]            cyf1_d;
  logic [CX_W-1:0]             cx1_q;
  logic [CY_W-1:0]             cy1_q;

  always_comb begin
    ok1_d = (in_depth != '0) && (in_depth < depth_limit_q) &&
            (32'(in_col) < 32'(dpb_pkg::FRAME_WIDTH)) &&
            (32'(in_row) < 32'(dpb_pkg::FRAME_HEIGHT));
    dx1_d = $signed(DIFF_W'({in_col, 4'b0000})) - $signed({1'b0, principal_x_q});
    dy1_d = $signed(DIFF_W'({in_row, 4'b0000})) - $signed({1'b0, principal_y_q});
    cxf1_d = CXF_W'(in_col) * CXF_W'(color_scale_x_q);
    cyf1_d = CYF_W'(in_row) * CYF_W'(color_scale_y_q);
  end

  // --------------------------------------------------------------------------
  // Stage 2: offset times depth, scaled colour row times row width
  // --------------------------------------------------------------------------
  logic signed [PD_W:0]        pdx_full, pdy_full;
  logic signed [PD_W-1:0]      pdx2_q, pdy2_q;
  logic                        ok2_q;
  logic [dpb_pkg::DEPTH_W-1:0] dep2_q;
  logic [CYW_W-1:0]            cyw2_d;
  logic [dpb_pkg::CIDX_W-1:0]  cyw2_q;
  logic [CX_W-1:0]             cx2_q;

  always_comb begin
    pdx_full = dx1_q * $signed({1'b0, dep1_q});
    pdy_full = dy1_q * $signed({1'b0, dep1_q});
    cyw2_d   = CYW_W'(cy1_q) * CYW_W'(color_row_width_q);
  end

  // --------------------------------------------------------------------------
  // Stage 3: times inverse focal length, colour index sum
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]    px3_d, py3_d, px3_q, py3_q;
  logic                        ok3_q;
  logic [dpb_pkg::DEPTH_W-1:0] dep3_q;
  logic [dpb_pkg::CIDX_W-1:0]  cidx3_d, cidx3_q;

  always_comb begin
    px3_d   = PROD_W'(pdx2_q) * PROD_W'($signed({1'b0, inv_focal_x_q}));
    py3_d   = PROD_W'(pdy2_q) * PROD_W'($signed({1'b0, inv_focal_y_q}));
    cidx3_d = cyw2_q + dpb_pkg::CIDX_W'(cx2_q);
  end

  // --------------------------------------------------------------------------
  // Stage 4: round half up, saturate, blank invalid points
  // --------------------------------------------------------------------------
  function automatic logic [dpb_pkg::POS_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    logic signed [SHR_W-1:0]  r;
    logic [dpb_pkg::POS_W-1:0] res;
    // floor((p + 2^23) / 2^24) is the tie-up rounding for both signs
    q = p + PROD_W'(1 << 23);
    r = SHR_W'(q >>> 24);
    if (!r[SHR_W-1] && (r[SHR_W-2:dpb_pkg::POS_W-1] != '0)) begin
      res = {1'b0, {(dpb_pkg::POS_W-1){1'b1}}};
    end else if (r[SHR_W-1] && (r[SHR_W-2:dpb_pkg::POS_W-1] != '1)) begin
      res = {1'b1, {(dpb_pkg::POS_W-1){1'b0}}};
    end else begin
      res = r[dpb_pkg::POS_W-1:0];
    end
    return res;
  endfunction

  logic [dpb_pkg::POS_W-1:0]   x4_d, y4_d, x4_q, y4_q;
  logic [dpb_pkg::DEPTH_W-1:0] z4_d, z4_q;
  logic [dpb_pkg::CIDX_W-1:0]  cidx4_d, cidx4_q;
  logic                        ok4_q;

  always_comb begin
    if (ok3_q) begin
      x4_d    = round_sat(px3_q);
      y4_d    = round_sat(py3_q);
      z4_d    = dep3_q;
      cidx4_d = cidx3_q;
    end else begin
      x4_d    = '0;
      y4_d    = '0;
      z4_d    = '0;
      cidx4_d = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok1_q   <= ok1_d;
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      dep1_q  <= in_depth;
      cx1_q   <= cxf1_d[CXF_W-1:16];
      cy1_q   <= cyf1_d[CYF_W-1:16];

      ok2_q   <= ok1_q;
      pdx2_q  <= pdx_full[PD_W-1:0];
      pdy2_q  <= pdy_full[PD_W-1:0];
      dep2_q  <= dep1_q;
      cyw2_q  <= cyw2_d[dpb_pkg::CIDX_W-1:0];
      cx2_q   <= cx1_q;

      ok3_q   <= ok2_q;
      px3_q   <= px3_d;
      py3_q   <= py3_d;
      dep3_q  <= dep2_q;
      cidx3_q <= cidx3_d;

      ok4_q   <= ok3_q;
      x4_q    <= x4_d;
      y4_q    <= y4_d;
      z4_q    <= z4_d;
      cidx4_q <= cidx4_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tuser  = ok4_q;
  assign m_axis_tdata  = dpb_pkg::OUT_DATA_W'({cidx4_q, z4_q, y4_q, x4_q});

endmodule
